// ----- hw/rtl/sbs_pkg.sv -----
// Shared constants and control types for the sensor batch statistics block.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sbs_pkg;

	// Batch size limit; readings past it are dropped
	localparam int MAX_READINGS = 128;

	// Field widths
	localparam int DATA_W    = 16;
	localparam int OUT_CNT_W = 8;
	localparam int CFG_IDX_W = 2;

	// Exact count width, and a sum wide enough for a full batch of positive readings
	localparam int CNT_W  = $clog2(MAX_READINGS + 1);
	localparam int SUM_W  = (DATA_W - 1) + CNT_W;
	localparam int STEP_W = $clog2(SUM_W + 1);

	localparam logic [CNT_W:0] MAX_TOTAL = (CNT_W + 1)'(MAX_READINGS);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WARNING  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN = 2'd2;

	// Threshold reset values, 1/16 degree
	localparam logic signed [DATA_W-1:0] WARNING_RESET  = 16'sd480;
	localparam logic signed [DATA_W-1:0] CRITICAL_RESET = 16'sd720;
	localparam logic signed [DATA_W-1:0] SHUTDOWN_RESET = 16'sd960;

	localparam logic signed [DATA_W-1:0] MIN_RESET = 16'sh7FFF;
	localparam logic signed [DATA_W-1:0] MAX_RESET = 16'sh8000;

	// Controller to datapath commands
	typedef struct packed {
		logic acc_en;
		logic snap_ld;
		logic div_start;
		logic out_ld;
	} sbs_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
	} sbs_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sbs_div.sv -----
// Restoring divider for the batch average, one quotient bit per cycle.
// Depends on sbs_pkg for the sum and count widths.
`timescale 1ns / 1ps
`default_nettype none

module sbs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sbs_pkg::SUM_W-1:0]   dividend,
	input  logic [sbs_pkg::CNT_W-1:0]   divisor,
	output logic [sbs_pkg::SUM_W-1:0]   quotient,
	output logic                        done
);
	import sbs_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    trial_sub;
	logic              fits;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		trial     = {rem_q, quo_q[SUM_W-1]};
		fits      = trial >= {1'b0, dvs_q};
		trial_sub = trial - {1'b0, dvs_q};
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sbs_datapath.sv -----
// Datapath: threshold registers, batch accumulators, end-of-batch snapshot,
// average divider and output register. Depends on sbs_pkg and sbs_div.
`timescale 1ns / 1ps
`default_nettype none

module sbs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sbs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sbs_pkg::DATA_W-1:0]          cfg_data,
	input  logic signed [sbs_pkg::DATA_W-1:0]   reading,
	input  sbs_pkg::sbs_cmd_t                   cmd,
	output sbs_pkg::sbs_stat_t                  stat,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       valid_count,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       skipped_count,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       first_critical_index,
	output logic signed [sbs_pkg::DATA_W-1:0]   first_critical_value,
	output logic signed [sbs_pkg::DATA_W-1:0]   minimum,
	output logic signed [sbs_pkg::DATA_W-1:0]   maximum,
	output logic signed [sbs_pkg::DATA_W-1:0]   average,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       normal_count,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       warning_count,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       critical_band_count,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       shutdown_count
);
	import sbs_pkg::*;

	localparam int NUM_BANDS = 4;
	localparam logic [1:0] BAND_NORMAL   = 2'd0;
	localparam logic [1:0] BAND_WARNING  = 2'd1;
	localparam logic [1:0] BAND_CRITICAL = 2'd2;
	localparam logic [1:0] BAND_SHUTDOWN = 2'd3;

	// Thresholds
	logic signed [DATA_W-1:0] warn_th_q;
	logic signed [DATA_W-1:0] crit_th_q;
	logic signed [DATA_W-1:0] shut_th_q;

	// Running batch state
	logic [SUM_W-1:0]         sum_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] max_q;
	logic [CNT_W-1:0]         good_q;
	logic [CNT_W-1:0]         skip_q;
	logic [CNT_W-1:0]         band_q [NUM_BANDS];
	logic [CNT_W-1:0]         crit_idx_q;
	logic signed [DATA_W-1:0] crit_val_q;
	logic                     crit_found_q;

	// Next values after the current request
	logic [SUM_W-1:0]         sum_nxt;
	logic signed [DATA_W-1:0] min_nxt;
	logic signed [DATA_W-1:0] max_nxt;
	logic [CNT_W-1:0]         good_nxt;
	logic [CNT_W-1:0]         skip_nxt;
	logic [CNT_W-1:0]         band_nxt [NUM_BANDS];
	logic [CNT_W-1:0]         crit_idx_nxt;
	logic signed [DATA_W-1:0] crit_val_nxt;
	logic                     crit_found_nxt;
	logic                     room;
	logic                     pos;
	logic                     take_good;
	logic                     take_skip;
	logic [1:0]               band;

	// End-of-batch snapshot
	logic [CNT_W-1:0]         snap_good_q;
	logic [CNT_W-1:0]         snap_skip_q;
	logic [CNT_W-1:0]         snap_crit_idx_q;
	logic signed [DATA_W-1:0] snap_crit_val_q;
	logic signed [DATA_W-1:0] snap_min_q;
	logic signed [DATA_W-1:0] snap_max_q;
	logic [CNT_W-1:0]         snap_band_q [NUM_BANDS];

	// Output register
	logic [OUT_CNT_W-1:0]     out_good_q;
	logic [OUT_CNT_W-1:0]     out_skip_q;
	logic [OUT_CNT_W-1:0]     out_crit_idx_q;
	logic signed [DATA_W-1:0] out_crit_val_q;
	logic signed [DATA_W-1:0] out_min_q;
	logic signed [DATA_W-1:0] out_max_q;
	logic signed [DATA_W-1:0] out_avg_q;
	logic [OUT_CNT_W-1:0]     out_band_q [NUM_BANDS];

	logic [SUM_W-1:0]         quotient;
	logic                     div_done;

	// Write thresholds; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_th_q <= WARNING_RESET;
			crit_th_q <= CRITICAL_RESET;
			shut_th_q <= SHUTDOWN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WARNING:  warn_th_q <= cfg_data;
				REG_CRITICAL: crit_th_q <= cfg_data;
				REG_SHUTDOWN: shut_th_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Classify the reading and work out the updated batch state
	always_comb begin
		room      = ({1'b0, good_q} + {1'b0, skip_q}) < MAX_TOTAL;
		pos       = reading > $signed(DATA_W'(0));
		take_good = cmd.acc_en && room && pos;
		take_skip = cmd.acc_en && room && !pos;

		if (reading >= shut_th_q)
			band = BAND_SHUTDOWN;
		else if (reading >= crit_th_q)
			band = BAND_CRITICAL;
		else if (reading >= warn_th_q)
			band = BAND_WARNING;
		else
			band = BAND_NORMAL;

		good_nxt = good_q + CNT_W'(take_good);
		skip_nxt = skip_q + CNT_W'(take_skip);
		sum_nxt  = take_good ? sum_q + SUM_W'($unsigned(reading)) : sum_q;
		min_nxt  = (take_good && reading < min_q) ? reading : min_q;
		max_nxt  = (take_good && reading > max_q) ? reading : max_q;

		for (int b = 0; b < NUM_BANDS; b++)
			band_nxt[b] = band_q[b] + CNT_W'(take_good && band == 2'(b));

		crit_found_nxt = crit_found_q;
		crit_idx_nxt   = crit_idx_q;
		crit_val_nxt   = crit_val_q;
		if (take_good && !crit_found_q && reading >= crit_th_q) begin
			crit_found_nxt = 1'b1;
			crit_idx_nxt   = good_nxt;
			crit_val_nxt   = reading;
		end
	end

	// Advance the batch state; clear it when the last reading goes to the snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			min_q        <= MIN_RESET;
			max_q        <= MAX_RESET;
			good_q       <= '0;
			skip_q       <= '0;
			crit_idx_q   <= '0;
			crit_val_q   <= '0;
			crit_found_q <= 1'b0;
			for (int b = 0; b < NUM_BANDS; b++)
				band_q[b] <= '0;
		end else if (cmd.snap_ld) begin
			sum_q        <= '0;
			min_q        <= MIN_RESET;
			max_q        <= MAX_RESET;
			good_q       <= '0;
			skip_q       <= '0;
			crit_idx_q   <= '0;
			crit_val_q   <= '0;
			crit_found_q <= 1'b0;
			for (int b = 0; b < NUM_BANDS; b++)
				band_q[b] <= '0;
		end else if (cmd.acc_en) begin
			sum_q        <= sum_nxt;
			min_q        <= min_nxt;
			max_q        <= max_nxt;
			good_q       <= good_nxt;
			skip_q       <= skip_nxt;
			crit_idx_q   <= crit_idx_nxt;
			crit_val_q   <= crit_val_nxt;
			crit_found_q <= crit_found_nxt;
			for (int b = 0; b < NUM_BANDS; b++)
				band_q[b] <= band_nxt[b];
		end
	end

	// Capture the finished batch; an empty batch reports zero extremes
	always_ff @(posedge clk) begin
		if (cmd.snap_ld) begin
			snap_good_q     <= good_nxt;
			snap_skip_q     <= skip_nxt;
			snap_crit_idx_q <= crit_idx_nxt;
			snap_crit_val_q <= crit_val_nxt;
			snap_min_q      <= (good_nxt == '0) ? '0 : min_nxt;
			snap_max_q      <= (good_nxt == '0) ? '0 : max_nxt;
			for (int b = 0; b < NUM_BANDS; b++)
				snap_band_q[b] <= band_nxt[b];
		end
	end

	// Average: sum over count, started on the final sum
	sbs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_nxt),
		.divisor  (good_nxt),
		.quotient (quotient),
		.done     (div_done)
	);

	assign stat.div_done = div_done;

	// Load the output register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_good_q     <= OUT_CNT_W'(snap_good_q);
			out_skip_q     <= OUT_CNT_W'(snap_skip_q);
			out_crit_idx_q <= OUT_CNT_W'(snap_crit_idx_q);
			out_crit_val_q <= snap_crit_val_q;
			out_min_q      <= snap_min_q;
			out_max_q      <= snap_max_q;
			out_avg_q      <= (snap_good_q == '0) ? '0 : DATA_W'(quotient);
			for (int b = 0; b < NUM_BANDS; b++)
				out_band_q[b] <= OUT_CNT_W'(snap_band_q[b]);
		end
	end

	assign valid_count          = out_good_q;
	assign skipped_count        = out_skip_q;
	assign first_critical_index = out_crit_idx_q;
	assign first_critical_value = out_crit_val_q;
	assign minimum              = out_min_q;
	assign maximum              = out_max_q;
	assign average              = out_avg_q;
	assign normal_count         = out_band_q[BAND_NORMAL];
	assign warning_count        = out_band_q[BAND_WARNING];
	assign critical_band_count  = out_band_q[BAND_CRITICAL];
	assign shutdown_count       = out_band_q[BAND_SHUTDOWN];

endmodule

`default_nettype wire

// ----- hw/rtl/sbs_ctrl.sv -----
// Controller: input stall, batch-end sequencing and output valid.
// Depends on sbs_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module sbs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output sbs_pkg::sbs_cmd_t  cmd,
	input  sbs_pkg::sbs_stat_t stat
);
	import sbs_pkg::*;

	localparam logic [1:0] ST_ACC  = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	// Take requests only while no batch end is pending
	always_comb begin
		in_stall      = (state_q != ST_ACC);
		accept        = in_valid && !in_stall;
		out_free      = !out_valid_q || !out_stall;
		cmd.acc_en    = accept;
		cmd.snap_ld   = accept && last;
		cmd.div_start = accept && last;
		cmd.out_ld    = ((state_q == ST_DIV && stat.div_done) || state_q == ST_HOLD)
		                && out_free;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_ACC: begin
				if (cmd.snap_ld)
					state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done)
					state_nxt = cmd.out_ld ? ST_ACC : ST_HOLD;
			end
			ST_HOLD: begin
				if (cmd.out_ld)
					state_nxt = ST_ACC;
			end
			default: state_nxt = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Never overwrite a result the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !(out_valid_q && out_stall))
		else $error("result overwritten while stalled");

	// The divider finishes only while a batch end is being worked on
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> state_q == ST_DIV)
		else $error("divider done outside of divide state");

	// A batch end always leads into the divide state
	a_snap_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.snap_ld |=> state_q == ST_DIV)
		else $error("batch end did not start the divide");

	// Loading a result frees the input side
	a_ld_release: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> !in_stall && out_valid)
		else $error("output load did not release intake");

endmodule

`default_nettype wire

// ----- hw/rtl/sensor_batch_statistics.sv -----
// Top level of the sensor batch statistics block: controller plus datapath.
// Depends on sbs_pkg, sbs_ctrl and sbs_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall, reading, last): one temperature reading
//   per request, signed, 1/16 degree. A request is taken at an edge with
//   in_valid high and in_stall low. Within a batch one reading is taken every
//   cycle. The request marked last closes the batch.
//   Output channel (out_valid / out_stall): one result per batch, from an
//   output register; it holds steady while out_stall is high.
//   Batch end: after the last reading the average comes from a restoring
//   divider that retires one quotient bit per cycle over the 23-bit sum;
//   in_stall stays high from then until the result is loaded into the
//   output register. A finished result waiting for the receiver does
//   not hold up intake: the next batch runs and only its own end waits for the
//   output register to free up.
//   Config port (cfg_we, cfg_index, cfg_data): thresholds 0 warning,
//   1 critical, 2 shutdown; write only while the block is idle.
//   Reset (arst_n low): thresholds return to 480 / 720 / 960, the batch is
//   cleared and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module sensor_batch_statistics (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sbs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sbs_pkg::DATA_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [sbs_pkg::DATA_W-1:0]   reading,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       valid_count,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       skipped_count,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       first_critical_index,
	output logic signed [sbs_pkg::DATA_W-1:0]   first_critical_value,
	output logic signed [sbs_pkg::DATA_W-1:0]   minimum,
	output logic signed [sbs_pkg::DATA_W-1:0]   maximum,
	output logic signed [sbs_pkg::DATA_W-1:0]   average,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       normal_count,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       warning_count,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       critical_band_count,
	output logic [sbs_pkg::OUT_CNT_W-1:0]       shutdown_count
);
	import sbs_pkg::*;

	sbs_cmd_t  cmd;
	sbs_stat_t stat;

	sbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	sbs_datapath u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.reading              (reading),
		.cmd                  (cmd),
		.stat                 (stat),
		.valid_count          (valid_count),
		.skipped_count        (skipped_count),
		.first_critical_index (first_critical_index),
		.first_critical_value (first_critical_value),
		.minimum              (minimum),
		.maximum              (maximum),
		.average              (average),
		.normal_count         (normal_count),
		.warning_count        (warning_count),
		.critical_band_count  (critical_band_count),
		.shutdown_count       (shutdown_count)
	);

endmodule

`default_nettype wire
